>>> rtl/perspective_floor_texel_top_assert.svh
// ----------------------------------------------------------------------------
// Perspective floor texel: assertion macros
// Shared property wrappers for the checker. Each one expects a signal named
// clock in the scope where it is used; PFT_ASSERT also expects reset there.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_FLOOR_TEXEL_TOP_ASSERT_SVH
`define PERSPECTIVE_FLOOR_TEXEL_TOP_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define PFT_ASSERT(lbl, body, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) body) \
      else $error(msg);

// Clocked assertion that also holds while reset is high.
`define PFT_ASSERT_ALWAYS(lbl, body, msg) \
   lbl: assert property (@(posedge clock) body) \
      else $error(msg);

`endif

>>> rtl/pft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perspective floor texel package
// Geometry, datapath widths, pipeline depths and codes shared by the floor
// texel pipeline, its divider lanes and its checker.
// ----------------------------------------------------------------------------
package pft_pkg;

   // Screen geometry and checker size. The texture repeats every 256 texels,
   // and the tile parity bit survives that wrap because the tile divides it.
   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 200;
   localparam int CHECKER_TILE  = 64;
   localparam int FOCAL         = 320;
   localparam int HALF_W        = SCREEN_WIDTH / 2;
   localparam int HALF_H        = SCREEN_HEIGHT / 2;

   // Port widths.
   localparam int ROW_W      = 8;
   localparam int COL_W      = 9;
   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int COLOR_W    = 2;

   // Datapath widths. The floor height of 16 times the Q22 scale of the
   // numerator is a shift by 26; the common denominator carries 2^36.
   localparam int RY_W        = ROW_W + 1;
   localparam int CX_W        = COL_W + 1;
   localparam int ABS_W       = ROW_W;
   localparam int P_W         = CX_W + CFG_W;
   localparam int D_W         = P_W + 1;
   localparam int K_W         = 2 * CFG_W;
   localparam int WK_W        = CFG_W + K_W;
   localparam int PW_W        = WK_W + ABS_W;
   localparam int N_W         = PW_W + 2;
   localparam int FLOOR_SHIFT = 26;
   localparam int DEN_SHIFT   = 36;
   localparam int AU_W        = N_W - DEN_SHIFT - 1;

   // Divider: only quotient bits down to the tile parity bit are produced.
   localparam int TILE_BIT     = $clog2(CHECKER_TILE);
   localparam int DIV_STEPS    = AU_W - TILE_BIT;
   localparam int DIV_BITS     = 3;
   localparam int DIV_STAGES   = (DIV_STEPS + DIV_BITS - 1) / DIV_BITS;
   localparam int FRONT_STAGES = 5;
   localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES;
   localparam int LATENCY      = PIPE_STAGES + 1;

   // Register reset values.
   localparam logic signed [CFG_W-1:0] COS_YAW_RESET   = 16384;
   localparam logic signed [CFG_W-1:0] SIN_YAW_RESET   = 0;
   localparam logic [CFG_W-1:0]        WALK_U_RESET    = '0;
   localparam logic [CFG_W-1:0]        WALK_V_RESET    = '0;
   localparam logic [ROW_W-1:0]        FIRST_ROW_RESET = 140;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COS_YAW   = 3'd0,
      CSR_SIN_YAW   = 3'd1,
      CSR_WALK_U    = 3'd2,
      CSR_WALK_V    = 3'd3,
      CSR_FIRST_ROW = 3'd4
   } csr_index_type;

   typedef enum logic [COLOR_W-1:0] {
      COLOR_SKY  = 2'd0,
      COLOR_ODD  = 2'd1,
      COLOR_EVEN = 2'd2
   } color_type;

endpackage

>>> rtl/pft_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floor texel divider lane
// Pipelined restoring division of a texel numerator by the row distance.
// Each stage retires a few quotient bits; the lane returns the tile parity
// bit of the floored, signed quotient.
// ----------------------------------------------------------------------------
module pft_div_lane (
   input  logic                      clock,
   input  logic [pft_pkg::AU_W-1:0]  dividend,
   input  logic [pft_pkg::ABS_W-1:0] divisor,
   input  logic                      negative,
   output logic                      parity
);

   localparam int AU_W       = pft_pkg::AU_W;
   localparam int ABS_W      = pft_pkg::ABS_W;
   localparam int DIV_STAGES = pft_pkg::DIV_STAGES;

   logic [AU_W-1:0]  num_ff [DIV_STAGES];
   logic [ABS_W-1:0] rem_ff [DIV_STAGES];
   logic [ABS_W-1:0] den_ff [DIV_STAGES];
   logic             neg_ff [DIV_STAGES];
   logic             q_ff   [DIV_STAGES];

   for (genvar st = 0; st < DIV_STAGES; st++) begin : g_stage
      logic [AU_W-1:0]  num_src;
      logic [ABS_W-1:0] rem_src;
      logic [ABS_W-1:0] den_src;
      logic             neg_src;
      logic             q_src;
      logic [AU_W-1:0]  num_in;
      logic [ABS_W-1:0] rem_in;
      logic             q_in;

      // The first stage starts from the new beat with an empty remainder.
      if (st == 0) begin : g_first
         assign num_src = dividend;
         assign rem_src = '0;
         assign den_src = divisor;
         assign neg_src = negative;
         assign q_src   = 1'b0;
      end else begin : g_next
         assign num_src = num_ff[st-1];
         assign rem_src = rem_ff[st-1];
         assign den_src = den_ff[st-1];
         assign neg_src = neg_ff[st-1];
         assign q_src   = q_ff[st-1];
      end

      // Shift in one dividend bit per step and subtract where it fits.
      always_comb begin
         logic [ABS_W:0] part;
         num_in = num_src;
         rem_in = rem_src;
         q_in   = q_src;
         part   = '0;
         for (int j = 0; j < pft_pkg::DIV_BITS; j++) begin
            if (st * pft_pkg::DIV_BITS + j < pft_pkg::DIV_STEPS) begin
               part   = {rem_in, num_in[AU_W-1]};
               num_in = {num_in[AU_W-2:0], 1'b0};
               if (part >= {1'b0, den_src}) begin
                  rem_in = ABS_W'(part - {1'b0, den_src});
                  q_in   = 1'b1;
               end else begin
                  rem_in = part[ABS_W-1:0];
                  q_in   = 1'b0;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         num_ff[st] <= num_in;
         rem_ff[st] <= rem_in;
         den_ff[st] <= den_src;
         neg_ff[st] <= neg_src;
         q_ff[st]   <= q_in;
      end
   end

   // A negative quotient was divided in one's complement form, so the
   // parity bit flips with the sign.
   assign parity = neg_ff[DIV_STAGES-1] ^ q_ff[DIV_STAGES-1];

endmodule

>>> rtl/perspective_floor_texel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perspective floor texel pipeline
// Returns the palette index of a yawed, walking checker floor for one screen
// pixel. A pixel beat (req_row, req_column) is taken at a rising edge where
// start is high and busy is low; busy is low except during reset, so a new
// pixel can enter on every clock. A pixel taken at a rising edge shows its
// result on rsp_color and rsp_drawn, marked by rsp_strobe, once it has passed
// every stage and the output register; one result per clock is sustained.
// The pipeline holds five front stages (offset, products, sums, walk
// product, numerator) and the five stages of the two divider lanes, which
// retire three quotient bits each. Results come out in order and cannot be
// held off. The csr_ port writes a register at any edge where csr_wr_en is
// high; writes belong to idle periods. Reset restores the register values
// and drops every pixel in flight.
// ----------------------------------------------------------------------------
module perspective_floor_texel_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [pft_pkg::ROW_W-1:0]      req_row,
   input  logic [pft_pkg::COL_W-1:0]      req_column,
   input  logic                           csr_wr_en,
   input  logic [pft_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pft_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                           rsp_strobe,
   output logic [pft_pkg::COLOR_W-1:0]    rsp_color,
   output logic                           rsp_drawn
);

   localparam int ROW_W       = pft_pkg::ROW_W;
   localparam int CFG_W       = pft_pkg::CFG_W;
   localparam int RY_W        = pft_pkg::RY_W;
   localparam int CX_W        = pft_pkg::CX_W;
   localparam int ABS_W       = pft_pkg::ABS_W;
   localparam int P_W         = pft_pkg::P_W;
   localparam int D_W         = pft_pkg::D_W;
   localparam int K_W         = pft_pkg::K_W;
   localparam int WK_W        = pft_pkg::WK_W;
   localparam int PW_W        = pft_pkg::PW_W;
   localparam int N_W         = pft_pkg::N_W;
   localparam int AU_W        = pft_pkg::AU_W;
   localparam int PIPE_STAGES = pft_pkg::PIPE_STAGES;

   typedef struct packed {
      logic valid;
      logic drawn;
      logic on_floor;
   } ctl_type;

   // Configuration registers.
   logic signed [CFG_W-1:0] cos_yaw_ff;
   logic signed [CFG_W-1:0] sin_yaw_ff;
   logic [CFG_W-1:0]        walk_u_ff;
   logic [CFG_W-1:0]        walk_v_ff;
   logic [ROW_W-1:0]        first_row_ff;

   // Terms that depend on configuration only.
   logic signed [K_W-1:0] cc_in;
   logic signed [K_W-1:0] ss_in;
   logic [K_W-1:0]        cc_ff;
   logic [K_W-1:0]        ss_ff;
   logic [K_W-1:0]        k_ff;
   logic [WK_W-1:0]       wuk_ff;
   logic [WK_W-1:0]       wvk_ff;

   // Control line that travels with the data.
   ctl_type ctl_in;
   ctl_type ctl_ff [PIPE_STAGES];

   // Stage 1: centered coordinates.
   logic signed [RY_W-1:0] s1_ry_in;
   logic signed [CX_W-1:0] s1_cx_in;
   logic signed [RY_W-1:0] s1_ry_ff;
   logic signed [CX_W-1:0] s1_cx_ff;

   // Stage 2: products with the yaw.
   logic signed [P_W-1:0] s2_pu_in;
   logic signed [P_W-1:0] s2_pv_in;
   logic signed [P_W-1:0] s2_fs_in;
   logic signed [P_W-1:0] s2_fc_in;
   logic [ABS_W-1:0]      s2_rabs_in;
   logic signed [P_W-1:0] s2_pu_ff;
   logic signed [P_W-1:0] s2_pv_ff;
   logic signed [P_W-1:0] s2_fs_ff;
   logic signed [P_W-1:0] s2_fc_ff;
   logic [ABS_W-1:0]      s2_rabs_ff;
   logic                  s2_rneg_ff;

   // Stage 3: rotated ray direction.
   logic signed [D_W-1:0] s3_du_in;
   logic signed [D_W-1:0] s3_dv_in;
   logic signed [D_W-1:0] s3_du_ff;
   logic signed [D_W-1:0] s3_dv_ff;
   logic [ABS_W-1:0]      s3_rabs_ff;
   logic                  s3_rneg_ff;

   // Stage 4: walk term and sign-corrected ray term.
   logic signed [D_W-1:0] s4_dn_u_in;
   logic signed [D_W-1:0] s4_dn_v_in;
   logic [PW_W-1:0]       s4_pw_u_in;
   logic [PW_W-1:0]       s4_pw_v_in;
   logic signed [D_W-1:0] s4_dn_u_ff;
   logic signed [D_W-1:0] s4_dn_v_ff;
   logic [PW_W-1:0]       s4_pw_u_ff;
   logic [PW_W-1:0]       s4_pw_v_ff;
   logic [ABS_W-1:0]      s4_rabs_ff;

   // Stage 5: floored numerators, folded to magnitude form.
   logic [N_W-1:0]   n_u_sum;
   logic [N_W-1:0]   n_v_sum;
   logic [AU_W-1:0]  s5_au_u_ff;
   logic [AU_W-1:0]  s5_au_v_ff;
   logic             s5_neg_u_ff;
   logic             s5_neg_v_ff;
   logic [ABS_W-1:0] s5_rabs_ff;

   // Divider results and output beat.
   logic                           par_u;
   logic                           par_v;
   logic [pft_pkg::COLOR_W-1:0]    color_in;
   logic                           rsp_strobe_ff;
   logic [pft_pkg::COLOR_W-1:0]    rsp_color_ff;
   logic                           rsp_drawn_ff;

   // The pipeline never stalls; only reset holds off a new pixel.
   assign busy = reset;

   // Register writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_yaw_ff   <= pft_pkg::COS_YAW_RESET;
         sin_yaw_ff   <= pft_pkg::SIN_YAW_RESET;
         walk_u_ff    <= pft_pkg::WALK_U_RESET;
         walk_v_ff    <= pft_pkg::WALK_V_RESET;
         first_row_ff <= pft_pkg::FIRST_ROW_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            pft_pkg::CSR_COS_YAW:   cos_yaw_ff   <= $signed(csr_wdata[CFG_W-1:0]);
            pft_pkg::CSR_SIN_YAW:   sin_yaw_ff   <= $signed(csr_wdata[CFG_W-1:0]);
            pft_pkg::CSR_WALK_U:    walk_u_ff    <= csr_wdata[CFG_W-1:0];
            pft_pkg::CSR_WALK_V:    walk_v_ff    <= csr_wdata[CFG_W-1:0];
            pft_pkg::CSR_FIRST_ROW: first_row_ff <= csr_wdata[ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Yaw norm k = c*c + s*s and the walk offsets scaled by it, registered at the
   // squares, at k and at the scaled offsets; this chain settles before any pixel needs it.
   assign cc_in = cos_yaw_ff * cos_yaw_ff;
   assign ss_in = sin_yaw_ff * sin_yaw_ff;

   always_ff @(posedge clock) begin
      cc_ff  <= $unsigned(cc_in);
      ss_ff  <= $unsigned(ss_in);
      k_ff   <= cc_ff + ss_ff;
      wuk_ff <= WK_W'(walk_u_ff) * WK_W'(k_ff);
      wvk_ff <= WK_W'(walk_v_ff) * WK_W'(k_ff);
   end

   // Entry: sky rows and the horizon row skip the floor color.
   assign ctl_in.valid    = start & ~busy;
   assign ctl_in.drawn    = (req_row >= first_row_ff);
   assign ctl_in.on_floor = (req_row >= first_row_ff) &&
                            (req_row != ROW_W'(pft_pkg::HALF_H));

   assign s1_ry_in = $signed(RY_W'(req_row) - RY_W'(pft_pkg::HALF_H));
   assign s1_cx_in = $signed(CX_W'(req_column) - CX_W'(pft_pkg::HALF_W));

   // Valid bits and flags move one stage per clock.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_STAGES; i++) begin
            ctl_ff[i] <= '0;
         end
         rsp_strobe_ff <= 1'b0;
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < PIPE_STAGES; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
         rsp_strobe_ff <= ctl_ff[PIPE_STAGES-1].valid;
      end
   end

   // Stage 1 registers.
   always_ff @(posedge clock) begin
      s1_ry_ff <= s1_ry_in;
      s1_cx_ff <= s1_cx_in;
   end

   // Stage 2: column times yaw, focal times yaw, and the row magnitude.
   assign s2_pu_in   = P_W'(s1_cx_ff) * P_W'(cos_yaw_ff);
   assign s2_pv_in   = P_W'(s1_cx_ff) * P_W'(sin_yaw_ff);
   assign s2_fs_in   = P_W'(sin_yaw_ff) * P_W'(pft_pkg::FOCAL);
   assign s2_fc_in   = P_W'(cos_yaw_ff) * P_W'(pft_pkg::FOCAL);
   assign s2_rabs_in = s1_ry_ff[RY_W-1] ? ABS_W'(-s1_ry_ff) : ABS_W'(s1_ry_ff);

   always_ff @(posedge clock) begin
      s2_pu_ff   <= s2_pu_in;
      s2_pv_ff   <= s2_pv_in;
      s2_fs_ff   <= s2_fs_in;
      s2_fc_ff   <= s2_fc_in;
      s2_rabs_ff <= s2_rabs_in;
      s2_rneg_ff <= s1_ry_ff[RY_W-1];
   end

   // Stage 3: ray direction projected on the yawed axes.
   assign s3_du_in = D_W'(s2_pu_ff) - D_W'(s2_fs_ff);
   assign s3_dv_in = D_W'(s2_pv_ff) + D_W'(s2_fc_ff);

   always_ff @(posedge clock) begin
      s3_du_ff   <= s3_du_in;
      s3_dv_ff   <= s3_dv_in;
      s3_rabs_ff <= s2_rabs_ff;
      s3_rneg_ff <= s2_rneg_ff;
   end

   // Stage 4: the numerator is taken with the sign of the row offset so the
   // divisor is always the positive row distance.
   assign s4_dn_u_in = s3_rneg_ff ? s3_du_ff : -s3_du_ff;
   assign s4_dn_v_in = s3_rneg_ff ? s3_dv_ff : -s3_dv_ff;
   assign s4_pw_u_in = PW_W'(wuk_ff) * PW_W'(s3_rabs_ff);
   assign s4_pw_v_in = PW_W'(wvk_ff) * PW_W'(s3_rabs_ff);

   always_ff @(posedge clock) begin
      s4_dn_u_ff <= s4_dn_u_in;
      s4_dn_v_ff <= s4_dn_v_in;
      s4_pw_u_ff <= s4_pw_u_in;
      s4_pw_v_ff <= s4_pw_v_in;
      s4_rabs_ff <= s3_rabs_ff;
   end

   // Stage 5: full numerator, floored by 2^36. A negative value goes to the
   // divider as its one's complement, which turns floor into truncation.
   assign n_u_sum = (N_W'(s4_dn_u_ff) << pft_pkg::FLOOR_SHIFT) - N_W'(s4_pw_u_ff);
   assign n_v_sum = (N_W'(s4_dn_v_ff) << pft_pkg::FLOOR_SHIFT) - N_W'(s4_pw_v_ff);

   always_ff @(posedge clock) begin
      s5_au_u_ff  <= n_u_sum[N_W-2:pft_pkg::DEN_SHIFT] ^ {AU_W{n_u_sum[N_W-1]}};
      s5_au_v_ff  <= n_v_sum[N_W-2:pft_pkg::DEN_SHIFT] ^ {AU_W{n_v_sum[N_W-1]}};
      s5_neg_u_ff <= n_u_sum[N_W-1];
      s5_neg_v_ff <= n_v_sum[N_W-1];
      s5_rabs_ff  <= s4_rabs_ff;
   end

   // Divider lanes for the two texel coordinates.
   pft_div_lane u_div_u (
      .clock    (clock),
      .dividend (s5_au_u_ff),
      .divisor  (s5_rabs_ff),
      .negative (s5_neg_u_ff),
      .parity   (par_u)
   );

   pft_div_lane u_div_v (
      .clock    (clock),
      .dividend (s5_au_v_ff),
      .divisor  (s5_rabs_ff),
      .negative (s5_neg_v_ff),
      .parity   (par_v)
   );

   // Checker color from the tile parities of both coordinates.
   always_comb begin
      if (!ctl_ff[PIPE_STAGES-1].on_floor) begin
         color_in = pft_pkg::COLOR_SKY;
      end else if (par_u ^ par_v) begin
         color_in = pft_pkg::COLOR_ODD;
      end else begin
         color_in = pft_pkg::COLOR_EVEN;
      end
   end

   always_ff @(posedge clock) begin
      rsp_color_ff <= color_in;
      rsp_drawn_ff <= ctl_ff[PIPE_STAGES-1].drawn;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_color  = rsp_color_ff;
   assign rsp_drawn  = rsp_drawn_ff;

endmodule

>>> rtl/pft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perspective floor texel checker
// Watches the top level's ports for fixed latency, one result per pixel and
// legal color codes. Attached to the top level by the bind below.
// ----------------------------------------------------------------------------
`include "perspective_floor_texel_top_assert.svh"

module pft_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic [pft_pkg::COLOR_W-1:0] rsp_color,
   input logic                        rsp_drawn
);

   // Every accepted pixel produces a beat after the fixed latency.
   `PFT_ASSERT(a_latency, start && !busy |-> ##(pft_pkg::LATENCY) rsp_strobe, "result beat missing")

   // No beat appears without a pixel accepted one latency earlier.
   `PFT_ASSERT(a_no_extra, rsp_strobe |-> $past(start && !busy, pft_pkg::LATENCY), "unexpected result beat")

   // Rows that are not drawn always show the sky color.
   `PFT_ASSERT(a_sky_color, rsp_strobe && !rsp_drawn |-> rsp_color == pft_pkg::COLOR_SKY, "sky row with floor color")

   // Only the three palette codes are ever delivered.
   `PFT_ASSERT(a_color_code, rsp_strobe |-> rsp_color == pft_pkg::COLOR_SKY || rsp_color == pft_pkg::COLOR_ODD || rsp_color == pft_pkg::COLOR_EVEN, "illegal color code")

endmodule

bind perspective_floor_texel_top pft_checker u_pft_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_color  (rsp_color),
   .rsp_drawn  (rsp_drawn)
);

>>> test/tb_perspective_floor_texel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perspective floor texel testbench
// Drives screen pixels into the floor texel pipeline with random gaps and
// checks every palette index against an exact rational-arithmetic predictor
// of the yawed, walking checker floor. A short directed part covers sky rows,
// the horizon row, rows above the horizon, out-of-range pixels, extreme and
// unnormalized yaw values, and writes to unused register indexes. Random
// phases then reprogram all registers between bursts of pixels.
// ----------------------------------------------------------------------------
module tb_perspective_floor_texel_top;

   localparam longint TEXTURE_PERIOD = 256;
   localparam longint FLOOR_HEIGHT   = -16;
   localparam int     CYCLE_LIMIT    = 100000;
   localparam int     RANDOM_PHASES  = 10;
   localparam int     PHASE_PIXELS   = 168;
   localparam int     GAP_PERCENT    = 28;

   // Register indexes that decode to nothing.
   localparam logic [pft_pkg::CSR_IDX_W-1:0] CSR_SPARE_LOW  = 3'd5;
   localparam logic [pft_pkg::CSR_IDX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   typedef struct packed {
      pft_pkg::color_type color;
      logic               drawn;
   } texel_result_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           start      = 1'b0;
   logic                           busy;
   logic [pft_pkg::ROW_W-1:0]      req_row    = '0;
   logic [pft_pkg::COL_W-1:0]      req_column = '0;
   logic                           csr_wr_en  = 1'b0;
   logic [pft_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [pft_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                           rsp_strobe;
   logic [pft_pkg::COLOR_W-1:0]    rsp_color;
   logic                           rsp_drawn;

   // Local copy of the register file.
   logic signed [pft_pkg::CFG_W-1:0] yaw_cos         = pft_pkg::COS_YAW_RESET;
   logic signed [pft_pkg::CFG_W-1:0] yaw_sin         = pft_pkg::SIN_YAW_RESET;
   logic [pft_pkg::CFG_W-1:0]        walk_u          = pft_pkg::WALK_U_RESET;
   logic [pft_pkg::CFG_W-1:0]        walk_v          = pft_pkg::WALK_V_RESET;
   logic [pft_pkg::ROW_W-1:0]        floor_first_row = pft_pkg::FIRST_ROW_RESET;

   texel_result_type pending_texels[$];
   texel_result_type oldest_texel;
   bit            gaps_on      = 1'b1;
   int            fail_count   = 0;
   int            cycle_count  = 0;
   int            sky_count    = 0;
   int            horizon_count = 0;
   int            odd_count    = 0;
   int            even_count   = 0;
   int            reg_writes   = 0;

   perspective_floor_texel_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_row    (req_row),
      .req_column (req_column),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_color  (rsp_color),
      .rsp_drawn  (rsp_drawn)
   );

   always #1 clock = ~clock;

   // Hard stop in case the pipeline hangs or drops results.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Floor division, rounding toward minus infinity.
   function automatic longint floor_quotient(input longint num, input longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && ((num < 0) != (den < 0)))
         q = q - 1;
      return q;
   endfunction

   function automatic longint wrap_texel(input longint t);
      longint m;
      m = t % TEXTURE_PERIOD;
      if (m < 0)
         m = m + TEXTURE_PERIOD;
      return m;
   endfunction

   // Exact texel coordinates over the common denominator ry * 2^36,
   // then the checker parity of the wrapped texel.
   function automatic texel_result_type predict_texel(
      input logic [pft_pkg::ROW_W-1:0] row,
      input logic [pft_pkg::COL_W-1:0] col);
      texel_result_type r;
      longint ry, cx, c, s, k, den, nu, nv, tu, tv;
      r.color = pft_pkg::COLOR_SKY;
      r.drawn = 1'b0;
      if (row < floor_first_row)
         return r;
      r.drawn = 1'b1;
      ry = longint'(row) - pft_pkg::HALF_H;
      if (ry == 0)
         return r;
      cx  = longint'(col) - pft_pkg::HALF_W;
      c   = longint'(yaw_cos);
      s   = longint'(yaw_sin);
      k   = c * c + s * s;
      den = ry * (longint'(1) << 36);
      nu  = FLOOR_HEIGHT * (cx * c - pft_pkg::FOCAL * s) * (longint'(1) << 22)
            - longint'(walk_u) * k * ry;
      nv  = FLOOR_HEIGHT * (cx * s + pft_pkg::FOCAL * c) * (longint'(1) << 22)
            - longint'(walk_v) * k * ry;
      tu  = wrap_texel(floor_quotient(nu, den));
      tv  = wrap_texel(floor_quotient(nv, den));
      r.color = (((tu / pft_pkg::CHECKER_TILE) ^ (tv / pft_pkg::CHECKER_TILE)) & 1) != 0
                ? pft_pkg::COLOR_ODD : pft_pkg::COLOR_EVEN;
      return r;
   endfunction

   // Send one pixel beat, with random idle cycles ahead of it.
   task automatic send_pixel(input logic [pft_pkg::ROW_W-1:0] row,
                             input logic [pft_pkg::COL_W-1:0] col);
      if (gaps_on) begin
         while ($urandom_range(99) < GAP_PERCENT) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start      <= 1'b1;
      req_row    <= row;
      req_column <= col;
      do @(posedge clock); while (busy);
      pending_texels.push_back(predict_texel(row, col));
   endtask

   // Stop sending and wait until every pending pixel has come back.
   task automatic drain_pixels();
      start <= 1'b0;
      while (pending_texels.size() != 0)
         @(posedge clock);
   endtask

   // Registers change only while the pipeline is empty.
   task automatic set_register(input logic [pft_pkg::CSR_IDX_W-1:0] idx,
                               input logic [pft_pkg::CSR_DATA_W-1:0] data);
      drain_pixels();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         pft_pkg::CSR_COS_YAW:   yaw_cos = data;
         pft_pkg::CSR_SIN_YAW:   yaw_sin = data;
         pft_pkg::CSR_WALK_U:    walk_u = data;
         pft_pkg::CSR_WALK_V:    walk_v = data;
         pft_pkg::CSR_FIRST_ROW: floor_first_row = data[pft_pkg::ROW_W-1:0];
         default:       ;
      endcase
      reg_writes++;
      @(posedge clock);
   endtask

   // Reset values: sky rows, the first drawn row and out-of-range pixels.
   task automatic test_reset_state();
      send_pixel(8'd0, 9'd0);
      send_pixel(8'd139, 9'd511);
      send_pixel(8'd140, 9'd0);
      send_pixel(8'd140, 9'd160);
      send_pixel(8'd199, 9'd319);
      send_pixel(8'd255, 9'd511);
      send_pixel(8'd150, 9'd255);
   endtask

   // Every row drawn: the horizon row and the mirrored plane above it.
   task automatic test_horizon_and_upper_rows();
      set_register(pft_pkg::CSR_FIRST_ROW, 16'd0);
      send_pixel(8'd100, 9'd0);
      send_pixel(8'd0, 9'd0);
      send_pixel(8'd99, 9'd511);
      send_pixel(8'd101, 9'd160);
      send_pixel(8'd50, 9'd300);
      send_pixel(8'd100, 9'd511);
   endtask

   // Extreme yaw and walk values, unused indexes and a zero yaw vector.
   task automatic test_yaw_and_walk_extremes();
      set_register(pft_pkg::CSR_COS_YAW, 16'hC000);
      set_register(pft_pkg::CSR_SIN_YAW, 16'h4000);
      set_register(pft_pkg::CSR_WALK_U, 16'hFFFF);
      set_register(pft_pkg::CSR_WALK_V, 16'hFFFF);
      set_register(pft_pkg::CSR_FIRST_ROW, 16'hFFC7);
      send_pixel(8'd198, 9'd5);
      send_pixel(8'd199, 9'd0);
      send_pixel(8'd255, 9'd0);
      send_pixel(8'd200, 9'd511);
      set_register(pft_pkg::CSR_COS_YAW, 16'h8000);
      set_register(pft_pkg::CSR_SIN_YAW, 16'h7FFF);
      set_register(pft_pkg::CSR_WALK_U, 16'h0000);
      set_register(pft_pkg::CSR_WALK_V, 16'h8000);
      set_register(pft_pkg::CSR_FIRST_ROW, 16'd0);
      send_pixel(8'd255, 9'd511);
      send_pixel(8'd101, 9'd0);
      send_pixel(8'd199, 9'd160);
      set_register(CSR_SPARE_LOW, 16'hFFFF);
      set_register(CSR_SPARE_HIGH, 16'hFFFF);
      set_register(pft_pkg::CSR_COS_YAW, 16'h0000);
      set_register(pft_pkg::CSR_SIN_YAW, 16'h0000);
      send_pixel(8'd180, 9'd100);
      send_pixel(8'd120, 9'd300);
   endtask

   function automatic logic [pft_pkg::CFG_W-1:0] random_yaw();
      int pick;
      pick = $urandom_range(9);
      if (pick < 6)
         return pft_pkg::CFG_W'($urandom_range(32768) - 16384);
      else if (pick < 8)
         return pft_pkg::CFG_W'($urandom);
      else
         return (pick == 8) ? 16'hC000 : 16'h4000;
   endfunction

   function automatic logic [pft_pkg::CFG_W-1:0] random_walk();
      case ($urandom_range(9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return pft_pkg::CFG_W'($urandom);
      endcase
   endfunction

   function automatic logic [pft_pkg::CSR_DATA_W-1:0] random_first_row();
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'd199;
         2:       return pft_pkg::CSR_DATA_W'($urandom);
         default: return pft_pkg::CSR_DATA_W'($urandom_range(199));
      endcase
   endfunction

   // Random register settings, each followed by a burst of pixels that
   // mostly land on drawn rows. One phase runs without any gaps.
   task automatic test_random_settings();
      logic [pft_pkg::ROW_W-1:0] row;
      logic [pft_pkg::COL_W-1:0] col;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_register(pft_pkg::CSR_COS_YAW, random_yaw());
         set_register(pft_pkg::CSR_SIN_YAW, random_yaw());
         set_register(pft_pkg::CSR_WALK_U, random_walk());
         set_register(pft_pkg::CSR_WALK_V, random_walk());
         set_register(pft_pkg::CSR_FIRST_ROW, random_first_row());
         if ($urandom_range(3) == 0)
            set_register(pft_pkg::CSR_IDX_W'($urandom_range(CSR_SPARE_HIGH, CSR_SPARE_LOW)),
                         pft_pkg::CSR_DATA_W'($urandom));
         gaps_on = (phase != 3);
         for (int i = 0; i < PHASE_PIXELS; i++) begin
            if ($urandom_range(19) == 0)
               row = pft_pkg::ROW_W'(pft_pkg::HALF_H);
            else if ($urandom_range(99) < 85)
               row = pft_pkg::ROW_W'($urandom_range(255, floor_first_row));
            else
               row = pft_pkg::ROW_W'($urandom_range(255));
            if ($urandom_range(99) < 80)
               col = pft_pkg::COL_W'($urandom_range(pft_pkg::SCREEN_WIDTH - 1));
            else
               col = pft_pkg::COL_W'($urandom_range(511));
            send_pixel(row, col);
         end
         gaps_on = 1'b1;
      end
   endtask

   // Compare each result beat with the oldest pending pixel.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_texels.size() == 0) begin
            $error("result beat with no pixel pending: color %0d drawn %0d",
                   rsp_color, rsp_drawn);
            fail_count++;
         end else begin
            oldest_texel = pending_texels.pop_front();
            if (rsp_color !== oldest_texel.color) begin
               $error("rsp_color mismatch: expected %0d, actual %0d",
                      oldest_texel.color, rsp_color);
               fail_count++;
            end
            if (rsp_drawn !== oldest_texel.drawn) begin
               $error("rsp_drawn mismatch: expected %0d, actual %0d",
                      oldest_texel.drawn, rsp_drawn);
               fail_count++;
            end
            if (!oldest_texel.drawn)
               sky_count++;
            else if (oldest_texel.color == pft_pkg::COLOR_SKY)
               horizon_count++;
            else if (oldest_texel.color == pft_pkg::COLOR_ODD)
               odd_count++;
            else
               even_count++;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_horizon_and_upper_rows();
      test_yaw_and_walk_extremes();
      test_random_settings();

      drain_pixels();
      repeat (pft_pkg::LATENCY + 4) @(posedge clock);
      if (pending_texels.size() != 0) begin
         $error("%0d pixels never produced a result", pending_texels.size());
         fail_count++;
      end

      $display("Checked %0d sky, %0d horizon and %0d floor pixels (%0d odd, %0d even).",
               sky_count, horizon_count, odd_count + even_count, odd_count, even_count);
      $display("Register writes: %0d, over %0d random settings plus directed extremes.",
               reg_writes, RANDOM_PHASES);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
